// ----- sv/htb_pkg.sv -----
package htb_pkg;

   localparam int unsigned MODE_W = 4;

   localparam logic [MODE_W-1:0] MODE_IDLE      = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SLASH     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_COMMENT   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_WS        = 4'd3;
   localparam logic [MODE_W-1:0] MODE_SIGNED    = 4'd4;
   localparam logic [MODE_W-1:0] MODE_ZERO_HEAD = 4'd5;
   localparam logic [MODE_W-1:0] MODE_ZERO      = 4'd6;
   localparam logic [MODE_W-1:0] MODE_PREFIX    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_DIGITS    = 4'd8;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_VT      = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       halted;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [63:0]       magnitude;
      logic              negative;
      logic              overflowed;
      logic              stopped;
   } state_type;

   localparam state_type RESET_STATE = '{
      mode:       MODE_IDLE,
      magnitude:  64'd0,
      negative:   1'b0,
      overflowed: 1'b0,
      stopped:    1'b0
   };

endpackage

// ----- sv/htb_step.sv -----
module htb_step (
   input  htb_pkg::state_type state,
   input  htb_pkg::req_type   word,
   output htb_pkg::state_type state_next,
   output htb_pkg::rsp_type   rsp
);

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b10000;
      if (c >= htb_pkg::CHAR_ZERO && c <= htb_pkg::CHAR_NINE) begin
         r = {1'b0, 4'(c - htb_pkg::CHAR_ZERO)};
      end else if (c >= htb_pkg::CHAR_LOWER_A && c <= htb_pkg::CHAR_LOWER_F) begin
         r = {1'b0, 4'(c - htb_pkg::CHAR_LOWER_A + 8'd10)};
      end else if (c >= htb_pkg::CHAR_UPPER_A && c <= htb_pkg::CHAR_UPPER_F) begin
         r = {1'b0, 4'(c - htb_pkg::CHAR_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

   function automatic logic is_c_space(input logic [7:0] c);
      return c == htb_pkg::CHAR_SPACE || c == htb_pkg::CHAR_TAB || c == htb_pkg::CHAR_LF ||
             c == htb_pkg::CHAR_VT || c == htb_pkg::CHAR_FF || c == htb_pkg::CHAR_CR;
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return c == htb_pkg::CHAR_PLUS || c == htb_pkg::CHAR_MINUS;
   endfunction

   function automatic logic is_x(input logic [7:0] c);
      return c == htb_pkg::CHAR_LOWER_X || c == htb_pkg::CHAR_UPPER_X;
   endfunction

   function automatic logic [7:0] token_byte(input htb_pkg::state_type s);
      logic [7:0] r;
      if (s.negative) begin
         if (s.overflowed || (s.magnitude[63] && |s.magnitude[62:0])) begin
            r = 8'h00;
         end else begin
            r = 8'(~s.magnitude[7:0] + 8'd1);
         end
      end else begin
         if (s.overflowed || s.magnitude[63]) begin
            r = 8'hFF;
         end else begin
            r = s.magnitude[7:0];
         end
      end
      return r;
   endfunction

   // Between tokens: the token fields are cleared and the character may open a new one.
   function automatic htb_pkg::state_type scan_idle(input htb_pkg::state_type s,
                                                   input logic [7:0] c);
      htb_pkg::state_type r;
      logic [4:0]         h;
      h            = hex_val(c);
      r            = s;
      r.magnitude  = 64'd0;
      r.negative   = 1'b0;
      r.overflowed = 1'b0;
      r.mode       = htb_pkg::MODE_IDLE;
      if (c == htb_pkg::CHAR_SPACE || c == htb_pkg::CHAR_LF || c == htb_pkg::CHAR_TAB) begin
         r.mode = htb_pkg::MODE_IDLE;
      end else if (c == htb_pkg::CHAR_SLASH) begin
         r.mode = htb_pkg::MODE_SLASH;
      end else if (c == htb_pkg::CHAR_NUL) begin
         r.stopped = 1'b1;
      end else if (c == htb_pkg::CHAR_ZERO) begin
         r.mode = htb_pkg::MODE_ZERO_HEAD;
      end else if (!h[4]) begin
         r.magnitude = {60'd0, h[3:0]};
         r.mode      = htb_pkg::MODE_DIGITS;
      end else if (is_c_space(c)) begin
         r.mode = htb_pkg::MODE_WS;
      end else if (is_sign(c)) begin
         r.negative = (c == htb_pkg::CHAR_MINUS);
         r.mode     = htb_pkg::MODE_SIGNED;
      end else begin
         r.stopped = 1'b1;
      end
      return r;
   endfunction

   htb_pkg::state_type st;
   logic [7:0]         c;
   logic [4:0]         h;
   logic               valid;
   logic [7:0]         b;

   always_comb begin
      st    = state;
      c     = word.in_char;
      h     = hex_val(word.in_char);
      valid = 1'b0;
      b     = 8'h00;

      if (!state.stopped) begin
         unique case (state.mode)
            htb_pkg::MODE_IDLE: begin
               st = scan_idle(state, c);
            end
            htb_pkg::MODE_SLASH: begin
               if (c == htb_pkg::CHAR_SLASH) begin
                  st.mode = htb_pkg::MODE_COMMENT;
               end else begin
                  st.stopped = 1'b1;
               end
            end
            htb_pkg::MODE_COMMENT: begin
               if (c == htb_pkg::CHAR_LF) begin
                  st.mode = htb_pkg::MODE_IDLE;
               end
            end
            htb_pkg::MODE_WS: begin
               if (is_c_space(c)) begin
                  st.mode = htb_pkg::MODE_WS;
               end else if (is_sign(c)) begin
                  st.negative = (c == htb_pkg::CHAR_MINUS);
                  st.mode     = htb_pkg::MODE_SIGNED;
               end else if (c == htb_pkg::CHAR_ZERO) begin
                  st.mode = htb_pkg::MODE_ZERO;
               end else if (!h[4]) begin
                  st.magnitude = {60'd0, h[3:0]};
                  st.mode      = htb_pkg::MODE_DIGITS;
               end else begin
                  st.stopped = 1'b1;
               end
            end
            htb_pkg::MODE_SIGNED: begin
               if (c == htb_pkg::CHAR_ZERO) begin
                  st.mode = htb_pkg::MODE_ZERO;
               end else if (!h[4]) begin
                  st.magnitude = {60'd0, h[3:0]};
                  st.mode      = htb_pkg::MODE_DIGITS;
               end else begin
                  st.stopped = 1'b1;
               end
            end
            htb_pkg::MODE_ZERO_HEAD: begin
               if (c == htb_pkg::CHAR_ZERO) begin
                  valid = 1'b1;
                  st    = scan_idle(state, htb_pkg::CHAR_SPACE);
               end else if (is_x(c)) begin
                  st.mode = htb_pkg::MODE_PREFIX;
               end else if (!h[4]) begin
                  st.magnitude = {60'd0, h[3:0]};
                  st.mode      = htb_pkg::MODE_DIGITS;
               end else begin
                  valid = 1'b1;
                  st    = scan_idle(state, c);
               end
            end
            htb_pkg::MODE_ZERO: begin
               if (is_x(c)) begin
                  st.mode = htb_pkg::MODE_PREFIX;
               end else if (!h[4]) begin
                  st.magnitude = {60'd0, h[3:0]};
                  st.mode      = htb_pkg::MODE_DIGITS;
               end else begin
                  valid = 1'b1;
                  st    = scan_idle(state, c);
               end
            end
            htb_pkg::MODE_PREFIX: begin
               if (!h[4]) begin
                  st.magnitude = {60'd0, h[3:0]};
                  st.mode      = htb_pkg::MODE_DIGITS;
               end else begin
                  valid      = 1'b1;
                  st.stopped = 1'b1;
               end
            end
            default: begin
               if (!h[4]) begin
                  if (!state.overflowed) begin
                     if (|state.magnitude[63:60]) begin
                        st.overflowed = 1'b1;
                     end else begin
                        st.magnitude = {state.magnitude[59:0], h[3:0]};
                     end
                  end
               end else begin
                  valid = 1'b1;
                  b     = token_byte(state);
                  st    = scan_idle(state, c);
               end
            end
         endcase
      end

      // At the end of the text a pending token is flushed, or a half-read one halts.
      if (word.end_of_input && !st.stopped && !valid) begin
         unique case (st.mode)
            htb_pkg::MODE_ZERO_HEAD, htb_pkg::MODE_ZERO: begin
               valid = 1'b1;
            end
            htb_pkg::MODE_DIGITS: begin
               valid = 1'b1;
               b     = token_byte(st);
            end
            htb_pkg::MODE_PREFIX: begin
               valid      = 1'b1;
               st.stopped = 1'b1;
            end
            htb_pkg::MODE_SLASH, htb_pkg::MODE_WS, htb_pkg::MODE_SIGNED: begin
               st.stopped = 1'b1;
            end
            default: begin
               valid = 1'b0;
            end
         endcase
      end

      rsp.byte_valid = valid;
      rsp.out_byte   = b;
      rsp.halted     = st.stopped;
      state_next     = word.end_of_input ? htb_pkg::RESET_STATE : st;
   end

endmodule

// ----- sv/hex_text_to_byte_parser.sv -----
// Channel | Ports                           | Word
// input   | req_valid, req_stall, req_word  | htb_pkg::req_type: in_char, end_of_input
// result  | rsp_valid, rsp_stall, rsp_word  | htb_pkg::rsp_type: byte_valid, out_byte, halted
//
// Each character gives exactly one result word, through the input and result registers.
// One character is taken every cycle unless stalled; parse state updates with the result.
// Reset returns the parser to idle between tokens with no halt pending.
// A stall on the result side holds the result register and, behind it, the input register.
module hex_text_to_byte_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htb_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htb_pkg::rsp_type rsp_word
);

   logic               in_valid_ff;
   logic               in_valid_in;
   htb_pkg::req_type   in_word_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   htb_pkg::rsp_type   out_word_ff;
   htb_pkg::state_type state_ff;
   htb_pkg::state_type state_next;
   htb_pkg::rsp_type   step_rsp;
   logic               advance;
   logic               step;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   htb_step u_step (
      .state      (state_ff),
      .word       (in_word_ff),
      .state_next (state_next),
      .rsp        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= htb_pkg::RESET_STATE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_word_ff <= req_word;
      end
      if (step) begin
         out_word_ff <= step_rsp;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      step && in_word_ff.end_of_input |=> state_ff == htb_pkg::RESET_STATE)
      else $error("State not cleared after the last character.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.stopped && !(step && in_word_ff.end_of_input) |=> state_ff.stopped)
      else $error("Halt released before the end of the text.");

   assert property (@(posedge clock) disable iff (reset)
      step && state_ff.stopped |=> out_valid_ff && !out_word_ff.byte_valid && out_word_ff.halted)
      else $error("Byte produced while halted.");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("Held input word was overwritten.");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_word_ff.byte_valid |-> out_word_ff.out_byte == 8'h00)
      else $error("Byte value present without a completed token.");

endmodule
